// ===== sv/gifad_pkg.sv =====
// ---------------------------------------------------------------------------
// gifad_pkg: shared types and constants for the GIF animation detector
// Parse phases, verdict reason codes, block introducer bytes and the
// colour table length helper.
// ---------------------------------------------------------------------------
`default_nettype none

package gifad_pkg;

    typedef enum logic [3:0] {
        PH_SIG_G      = 4'd0,
        PH_SIG_I      = 4'd1,
        PH_SIG_F      = 4'd2,
        PH_HEAD_SKIP  = 4'd3,
        PH_SCR_PACKED = 4'd4,
        PH_SCR_TAIL   = 4'd5,
        PH_GTABLE     = 4'd6,
        PH_BLOCK      = 4'd7,
        PH_EXT_LABEL  = 4'd8,
        PH_IMG_DESC   = 4'd9,
        PH_SUB_LEN    = 4'd10,
        PH_IMG_PACKED = 4'd11,
        PH_LTABLE     = 4'd12,
        PH_LZW        = 4'd13,
        PH_SUB_DATA   = 4'd14
    } phase_t;

    typedef enum logic [2:0] {
        RS_FRAME   = 3'd0,
        RS_TRAILER = 3'd1,
        RS_BADSIG  = 3'd2,
        RS_UNKNOWN = 3'd3,
        RS_TRUNC   = 3'd4
    } reason_t;

    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_I       = 8'h49;
    localparam logic [7:0] CHAR_F       = 8'h46;

    localparam int SKIP_W = 10;

    localparam logic [SKIP_W-1:0] HEAD_SKIP_LEN = 10'd7;
    localparam logic [SKIP_W-1:0] SCR_TAIL_LEN  = 10'd2;
    localparam logic [SKIP_W-1:0] IMG_DESC_LEN  = 10'd8;

    // One byte step of the parser: whether it gives a verdict, and which.
    typedef struct packed {
        logic    have;
        logic    animated;
        reason_t reason;
    } verdict_t;

    // Colour table size from a packed field byte: 3 * 2^(n+1) when bit 7 is set.
    function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] packed_byte);
        logic [3:0] sh;
        sh = {1'b0, packed_byte[2:0]} + 4'd1;
        if (!packed_byte[7]) begin
            return '0;
        end
        return SKIP_W'(10'd3 << sh);
    endfunction

endpackage

`default_nettype wire

// ===== sv/gifad_in_reg.sv =====
// ---------------------------------------------------------------------------
// gifad_in_reg: input word register
// Holds one byte and its last flag until the parser steps on it.
// ---------------------------------------------------------------------------
`default_nettype none

module gifad_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       step,
    output logic            byte_valid,
    output logic [7:0]      byte_data,
    output logic            byte_last
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready   = !valid_reg || step;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
    assign byte_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gifad_parser.sv =====
// ---------------------------------------------------------------------------
// gifad_parser: GIF block structure walker
// Updates the parse state by one byte per step and flags the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module gifad_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [7:0]         byte_data,
    input  wire logic               byte_last,
    output gifad_pkg::verdict_t     verdict
);

    import gifad_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [SKIP_W-1:0] table_reg, table_next;
    logic              frame_reg, frame_next;
    logic              given_reg, given_next;

    logic [SKIP_W-1:0] skip_dec;
    logic              skip_fin;
    logic [SKIP_W-1:0] tbl_len;
    logic [7:0]        want;
    logic              have;
    logic              anim;
    reason_t           why;

    assign skip_dec = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : '0;
    assign skip_fin = (skip_dec == '0);
    assign tbl_len  = table_bytes(byte_data);

    always_comb begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        table_next = table_reg;
        frame_next = frame_reg;
        given_next = given_reg;
        have       = 1'b0;
        anim       = 1'b0;
        why        = RS_FRAME;
        want       = CHAR_G;

        if (!given_reg) begin
            unique case (phase_reg)
                PH_SIG_G, PH_SIG_I, PH_SIG_F: begin
                    want = (phase_reg == PH_SIG_G) ? CHAR_G :
                           (phase_reg == PH_SIG_I) ? CHAR_I : CHAR_F;
                    if (byte_data != want) begin
                        have = 1'b1;
                        why  = RS_BADSIG;
                    end else if (phase_reg == PH_SIG_F) begin
                        skip_next  = HEAD_SKIP_LEN;
                        phase_next = PH_HEAD_SKIP;
                    end else if (phase_reg == PH_SIG_G) begin
                        phase_next = PH_SIG_I;
                    end else begin
                        phase_next = PH_SIG_F;
                    end
                end
                PH_HEAD_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        phase_next = PH_SCR_PACKED;
                    end
                end
                PH_SCR_PACKED: begin
                    table_next = tbl_len;
                    skip_next  = SCR_TAIL_LEN;
                    phase_next = PH_SCR_TAIL;
                end
                PH_SCR_TAIL: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        if (table_reg != '0) begin
                            skip_next  = table_reg;
                            table_next = '0;
                            phase_next = PH_GTABLE;
                        end else begin
                            phase_next = PH_BLOCK;
                        end
                    end
                end
                PH_GTABLE: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        phase_next = PH_BLOCK;
                    end
                end
                PH_BLOCK: begin
                    if (byte_data == BYTE_TRAILER) begin
                        have = 1'b1;
                        why  = RS_TRAILER;
                    end else if (byte_data == BYTE_EXT) begin
                        phase_next = PH_EXT_LABEL;
                    end else if (byte_data == BYTE_IMAGE) begin
                        if (frame_reg) begin
                            have = 1'b1;
                            anim = 1'b1;
                            why  = RS_FRAME;
                        end else begin
                            frame_next = 1'b1;
                            skip_next  = IMG_DESC_LEN;
                            phase_next = PH_IMG_DESC;
                        end
                    end else begin
                        have = 1'b1;
                        why  = RS_UNKNOWN;
                    end
                end
                PH_EXT_LABEL: begin
                    phase_next = PH_SUB_LEN;
                end
                PH_IMG_DESC: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        phase_next = PH_IMG_PACKED;
                    end
                end
                PH_IMG_PACKED: begin
                    // The table length is taken straight from this byte.
                    if (tbl_len != '0) begin
                        skip_next  = tbl_len;
                        table_next = '0;
                        phase_next = PH_LTABLE;
                    end else begin
                        table_next = '0;
                        phase_next = PH_LZW;
                    end
                end
                PH_LTABLE: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        phase_next = PH_LZW;
                    end
                end
                PH_LZW: begin
                    phase_next = PH_SUB_LEN;
                end
                PH_SUB_LEN: begin
                    if (byte_data == 8'h00) begin
                        phase_next = PH_BLOCK;
                    end else begin
                        skip_next  = SKIP_W'(byte_data);
                        phase_next = PH_SUB_DATA;
                    end
                end
                PH_SUB_DATA: begin
                    skip_next = skip_dec;
                    if (skip_fin) begin
                        phase_next = PH_SUB_LEN;
                    end
                end
                default: begin
                    phase_next = PH_BLOCK;
                end
            endcase

            if (!have && byte_last) begin
                have = 1'b1;
                anim = 1'b0;
                why  = RS_TRUNC;
            end
            if (have) begin
                given_next = 1'b1;
            end
        end

        // The last word of a file returns the parser to its start.
        if (byte_last) begin
            phase_next = PH_SIG_G;
            skip_next  = '0;
            table_next = '0;
            frame_next = 1'b0;
            given_next = 1'b0;
        end
    end

    always_comb begin
        verdict.have     = step && have;
        verdict.animated = anim;
        verdict.reason   = why;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG_G;
            skip_reg  <= '0;
            table_reg <= '0;
            frame_reg <= 1'b0;
            given_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            table_reg <= table_next;
            frame_reg <= frame_next;
            given_reg <= given_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gifad_out_reg.sv =====
// ---------------------------------------------------------------------------
// gifad_out_reg: verdict result register
// Holds one verdict word until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module gifad_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  gifad_pkg::verdict_t      verdict,
    output logic                     slot_free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata
);

    import gifad_pkg::*;

    logic       valid_reg;
    logic       anim_reg;
    reason_t    reason_reg;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {4'b0000, reason_reg, anim_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= verdict.have;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && verdict.have) begin
            anim_reg   <= verdict.animated;
            reason_reg <= verdict.reason;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gif_animation_detector.sv =====
// ---------------------------------------------------------------------------
// gif_animation_detector: GIF animation detector
// Walks the block structure of a byte stream and gives one verdict a file.
// ---------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                   | tlast
//  s_      | in        | data_byte[7:0]                       | last_byte
//  m_      | out       | animated[0], reason[3:1], zero[7:4]  | -
//
// One byte is taken every cycle while no result word waits; the byte that decides
// a verdict passes through the input word register and then the result register.
// Reset is synchronous and returns the parser to the signature check.
// A waiting result word holds the parser; the input stalls once the input
// register is full as well.
// ---------------------------------------------------------------------------
`default_nettype none

module gif_animation_detector (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // animated[0], reason[3:1], zero[7:4]
);

    import gifad_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;
    logic       slot_free;
    logic       step;
    verdict_t   verdict;

    assign step = byte_valid && slot_free;

    gifad_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .step       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_last  (byte_last)
    );

    gifad_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_data (byte_data),
        .byte_last (byte_last),
        .verdict   (verdict)
    );

    gifad_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .verdict   (verdict),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Only a second image separator may report an animated file.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == RS_FRAME))
        else $error("animated verdict with a reason other than second frame");

    // Reason codes stay within the defined set and the pad bits stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= RS_TRUNC && m_tdata[7:4] == 4'h0))
        else $error("verdict word carries an undefined reason or pad bits");

    // A verdict is never taken from the parser while the result slot is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        verdict.have |-> step)
        else $error("verdict raised without a parser step");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
